FILE: rtl/dha_pkg.sv
// Shared types and constants for the distance histogram accumulator.
// Used by every module of the block; depends on nothing.

package dha_pkg;

    localparam int DIST_W     = 16;               // Q8.8 distance and bounds
    localparam int NB_W       = 11;               // num_bins register
    localparam int SEL_W      = 10;               // bin_select and bin_index
    localparam int CNT_W      = 32;               // bin counts and total
    localparam int FUNC_W     = 2;
    localparam int QUO_W      = NB_W;             // quotient is below the active bin count
    localparam int NUM_W      = DIST_W + NB_W;    // (d - lo) * nb
    localparam int DSH_W      = DIST_W + QUO_W - 1;
    localparam int STEP_W     = 4;                // holds QUO_W - 1
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 80;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS = 2'd2;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd0;
    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 16'd65535;
    localparam logic [NB_W-1:0]   NUM_BINS_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SKIP,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [NUM_W-1:0] num;
        logic [DIST_W-1:0] den;
        logic [SEL_W-1:0] sel;
        logic             sel_ok;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_RDA,
        ST_UPD,
        ST_CLR
    } back_state_t;

endpackage

FILE: rtl/dha_front.sv
// Front end: configuration registers, beat acceptance and classification.
// Depends on dha_pkg; feeds commands into dha_queue.

module dha_front #(
    parameter int MAX_BINS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dha_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dha_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dha_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [dha_pkg::FUNC_W-1:0]      s_tuser,
    input  logic                            q_full,
    input  dha_pkg::back_status_t           status,
    output logic                            push,
    output dha_pkg::cmd_t                   push_cmd
);

    logic [dha_pkg::DIST_W-1:0] min_reg, min_next;
    logic [dha_pkg::DIST_W-1:0] max_reg, max_next;
    logic [dha_pkg::NB_W-1:0]   nbins_reg, nbins_next;

    logic [dha_pkg::DIST_W-1:0] sample_dist;
    logic [dha_pkg::SEL_W-1:0]  sel;
    logic [dha_pkg::DIST_W-1:0] lo;
    logic [dha_pkg::DIST_W-1:0] hi;
    logic [dha_pkg::DIST_W-1:0] diff;
    logic [dha_pkg::NB_W-1:0]   nb;
    logic                       in_rng;

    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        nbins_next = nbins_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                dha_pkg::CFG_MIN_DIST: min_next   = cfg_wdata;
                dha_pkg::CFG_MAX_DIST: max_next   = cfg_wdata;
                dha_pkg::CFG_NUM_BINS: nbins_next = cfg_wdata[dha_pkg::NB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= dha_pkg::MIN_DIST_RESET;
            max_reg   <= dha_pkg::MAX_DIST_RESET;
            nbins_reg <= dha_pkg::NUM_BINS_RESET;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            nbins_reg <= nbins_next;
        end
    end

    assign sample_dist = s_tdata[dha_pkg::DIST_W-1:0];
    assign sel         = s_tdata[dha_pkg::DIST_W +: dha_pkg::SEL_W];

    always_comb begin
        // order the bounds so that lo <= hi
        if (max_reg < min_reg) begin
            lo = max_reg;
            hi = min_reg;
        end else begin
            lo = min_reg;
            hi = max_reg;
        end
        in_rng = (sample_dist >= lo) && (sample_dist < hi);
        diff   = sample_dist - lo;

        if (nbins_reg == '0) begin
            nb = dha_pkg::NB_W'(1);
        end else if (32'(nbins_reg) > 32'(MAX_BINS)) begin
            nb = dha_pkg::NB_W'(MAX_BINS);
        end else begin
            nb = nbins_reg;
        end

        push_cmd.num    = dha_pkg::NUM_W'(diff) * dha_pkg::NUM_W'(nb);
        push_cmd.den    = hi - lo;
        push_cmd.sel    = sel;
        push_cmd.sel_ok = 32'(sel) < 32'(MAX_BINS);

        unique case (s_tuser)
            dha_pkg::FUNC_ADD:   push_cmd.op = in_rng ? dha_pkg::OP_ADD : dha_pkg::OP_SKIP;
            dha_pkg::FUNC_CLEAR: push_cmd.op = dha_pkg::OP_CLEAR;
            dha_pkg::FUNC_READ:  push_cmd.op = dha_pkg::OP_READ;
            default:             push_cmd.op = dha_pkg::OP_SKIP;
        endcase
    end

    assign s_tready = !q_full && !status.init_busy;
    assign push     = s_tvalid && s_tready;

endmodule

FILE: rtl/dha_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on dha_pkg for the command type.

module dha_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dha_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output dha_pkg::cmd_t head
);

    dha_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign valid = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/dha_back.sv
// Back end: radix-2 bin divider, bin count memory, clearing sweep, total and
// output register. Depends on dha_pkg; takes commands from dha_queue.

module dha_back #(
    parameter int MAX_BINS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  dha_pkg::cmd_t                  q_cmd,
    output logic                           pop,
    output dha_pkg::back_status_t          status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dha_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

    dha_pkg::back_state_t state_reg, state_next;
    dha_pkg::cmd_t        cmd_reg, cmd_next;

    logic [dha_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [dha_pkg::DSH_W-1:0]  dsh_reg, dsh_next;
    logic [dha_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [dha_pkg::STEP_W-1:0] step_reg, step_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [dha_pkg::CNT_W-1:0]  total_reg, total_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_range_reg, out_range_next;
    logic [dha_pkg::SEL_W-1:0]  out_idx_reg, out_idx_next;
    logic [dha_pkg::CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [dha_pkg::CNT_W-1:0]  out_total_reg, out_total_next;

    logic [dha_pkg::CNT_W-1:0]  mem [MAX_BINS];
    logic [dha_pkg::CNT_W-1:0]  rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [dha_pkg::CNT_W-1:0]  mem_wdata;

    logic                       out_free;
    logic                       last_addr;
    logic                       ge;
    logic [dha_pkg::CNT_W-1:0]  cnt_inc;
    logic [dha_pkg::SEL_W+AW-1:0]   sel_wide;
    logic [dha_pkg::QUO_W+AW-1:0]   quo_wide;

    assign out_free  = !out_valid_reg || m_tready;
    assign last_addr = (addr_reg == LAST_ADDR);
    assign ge        = (rem_reg >= dha_pkg::NUM_W'(dsh_reg));
    assign cnt_inc   = rd_data_reg + dha_pkg::CNT_W'(1);
    assign sel_wide  = {{AW{1'b0}}, q_cmd.sel};
    // quotient including the bit decided this cycle
    assign quo_wide  = {{AW{1'b0}}, quo_reg[dha_pkg::QUO_W-2:0], ge};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dha_pkg::ST_INIT: begin
                if (last_addr) state_next = dha_pkg::ST_IDLE;
            end
            dha_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        dha_pkg::OP_ADD:   state_next = dha_pkg::ST_DIV;
                        dha_pkg::OP_READ:  state_next = dha_pkg::ST_RDA;
                        dha_pkg::OP_CLEAR: state_next = dha_pkg::ST_CLR;
                        default:           state_next = dha_pkg::ST_UPD;
                    endcase
                end
            end
            dha_pkg::ST_DIV: begin
                if (step_reg == '0) state_next = dha_pkg::ST_RDA;
            end
            dha_pkg::ST_RDA: state_next = dha_pkg::ST_UPD;
            dha_pkg::ST_CLR: begin
                if (last_addr) state_next = dha_pkg::ST_UPD;
            end
            dha_pkg::ST_UPD: begin
                if (out_free) state_next = dha_pkg::ST_IDLE;
            end
            default: state_next = dha_pkg::ST_INIT;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_range_next = out_range_reg;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        out_total_next = out_total_reg;

        unique case (state_reg)
            dha_pkg::ST_INIT, dha_pkg::ST_CLR: begin
                mem_we    = 1'b1;
                addr_next = last_addr ? '0 : addr_reg + AW'(1);
            end
            dha_pkg::ST_IDLE: begin
                if (q_valid) begin
                    pop       = 1'b1;
                    cmd_next  = q_cmd;
                    rem_next  = q_cmd.num;
                    dsh_next  = dha_pkg::DSH_W'(q_cmd.den) << (dha_pkg::QUO_W - 1);
                    quo_next  = '0;
                    step_next = dha_pkg::STEP_W'(dha_pkg::QUO_W - 1);
                    addr_next = (q_cmd.op == dha_pkg::OP_READ) ? sel_wide[AW-1:0] : '0;
                    if (q_cmd.op == dha_pkg::OP_CLEAR) begin
                        total_next = '0;
                    end
                end
            end
            dha_pkg::ST_DIV: begin
                // one quotient bit per cycle, divisor shifted down each step
                if (ge) begin
                    rem_next = rem_reg - dha_pkg::NUM_W'(dsh_reg);
                end
                quo_next  = {quo_reg[dha_pkg::QUO_W-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - dha_pkg::STEP_W'(1);
                if (step_reg == '0) begin
                    addr_next = quo_wide[AW-1:0];
                end
            end
            dha_pkg::ST_RDA: begin
                mem_re = 1'b1;
            end
            dha_pkg::ST_UPD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_range_next = 1'b0;
                    out_idx_next   = '0;
                    out_cnt_next   = '0;
                    out_total_next = total_reg;
                    case (cmd_reg.op)
                        dha_pkg::OP_ADD: begin
                            mem_we         = 1'b1;
                            mem_wdata      = cnt_inc;
                            total_next     = total_reg + dha_pkg::CNT_W'(1);
                            out_range_next = 1'b1;
                            out_idx_next   = quo_reg[dha_pkg::SEL_W-1:0];
                            out_cnt_next   = cnt_inc;
                            out_total_next = total_reg + dha_pkg::CNT_W'(1);
                        end
                        dha_pkg::OP_READ: begin
                            out_idx_next = cmd_reg.sel;
                            out_cnt_next = cmd_reg.sel_ok ? rd_data_reg : '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dha_pkg::ST_INIT;
            addr_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        out_range_reg <= out_range_next;
        out_idx_reg   <= out_idx_next;
        out_cnt_reg   <= out_cnt_next;
        out_total_reg <= out_total_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign status.init_busy = (state_reg == dha_pkg::ST_INIT);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_range_reg;
    assign m_tdata  = {{(dha_pkg::M_TDATA_W - dha_pkg::SEL_W - 2 * dha_pkg::CNT_W){1'b0}},
                       out_total_reg, out_cnt_reg, out_idx_reg};

endmodule

FILE: rtl/distance_histogram_accumulator.sv
// Add beat: pop, 11 divider steps, memory read and update lie between acceptance
// and m_tvalid; the back end finishes each command before it pops the next one.
// Read beats skip the divider, skipped beats skip the read too, and a clear sweeps all bins.
// Reset: synchronous on aresetn low; configuration returns to its defaults and a
// clearing pass over all MAX_BINS bins of the bin memory runs with s_tready low.
// Depends on dha_pkg, dha_front, dha_queue and dha_back.

module distance_histogram_accumulator #(
    parameter int MAX_BINS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [dha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dha_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dha_pkg::S_TDATA_W-1:0]  s_tdata,   // distance[15:0], bin_select[25:16]
    input  logic [dha_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dha_pkg::M_TDATA_W-1:0]  m_tdata,   // bin_index[9:0], bin_count[41:10],
                                                      // total_count[73:42]
    output logic                           m_tuser    // in_range[0]
);

    logic                  push;
    dha_pkg::cmd_t         push_cmd;
    logic                  q_full;
    logic                  q_valid;
    logic                  pop;
    dha_pkg::cmd_t         q_head;
    dha_pkg::back_status_t status;

    dha_front #(
        .MAX_BINS(MAX_BINS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .status   (status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dha_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    dha_back #(
        .MAX_BINS(MAX_BINS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_head),
        .pop     (pop),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: rtl/dha_checker.sv
// Port-level assertions for the distance histogram accumulator, bound to the
// top level. Depends on dha_pkg and distance_histogram_accumulator.

module dha_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dha_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tuser
);

    // reset starts the clearing pass, so no beat is taken right after it
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high during the clearing pass after reset");

    // reset drops any pending result
    a_reset_drops_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed or dropped");

    a_out_flag_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tuser))
        else $error("stalled result beat changed its in_range flag");

endmodule

bind distance_histogram_accumulator dha_checker u_dha_checker (.*);
